>>> rtl/cst_pkg.sv
// Shared types and constants for the counting semaphore table unit.
// Has no dependencies. cst_ctrl, cst_dpath and the top level refer to it by scoped names.
package cst_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_NUM_SEMAPHORES = 16;
   localparam int DEF_NUM_TASKS      = 16;
   localparam int DEF_COUNT_BITS     = 8;

   // Fixed field widths.
   localparam int MODE_BITS   = 2;
   localparam int SEM_ID_BITS = 8;
   localparam int TASK_BITS   = 4;
   localparam int CEIL_BITS   = 8;
   localparam int STATUS_BITS = 3;

   // Only this many tasks can be named by a task id field.
   localparam int TASK_FIELD_LIMIT = 2 ** TASK_BITS;

   // Request modes.
   localparam logic [MODE_BITS-1:0] MODE_TRY_WAIT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WAIT     = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_POST     = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SET_CEIL = 2'd3;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOT_ACQUIRED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD_ID        = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_CEIL_UNSET    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_CEIL_EXCEEDED = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_BAD_CEIL      = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_CEIL_ALREADY  = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW      = 3'd7;

   typedef struct packed {
      logic [MODE_BITS-1:0]   mode;
      logic [SEM_ID_BITS-1:0] sem_id;
      logic [TASK_BITS-1:0]   task_id;
      logic [CEIL_BITS-1:0]   new_max;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   woken_valid;
      logic [TASK_BITS-1:0]   woken_task;
      logic                   last_result;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;
      logic read_sem;
      logic exec;
      logic load_wake;
      logic load_final;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic wake_any;
      logic wake_last;
   } sts_type;

endpackage

>>> rtl/cst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/cst_ctrl.sv
// Controller state machine for the semaphore table unit.
// Depends on cst_pkg for the command and status structs.
module cst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::sts_type sts,
   output cst_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_WAKE  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read_sem = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.wake_any ? S_WAKE : S_FINAL;
         end
         S_WAKE: begin
            if (sts.out_free) begin
               cmd.load_wake = 1'b1;
               if (sts.wake_last) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            if (sts.out_free) begin
               cmd.load_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/cst_dpath.sv
// Datapath: request register, semaphore table, waiter map and result register.
// Depends on cst_pkg and instantiates cst_ram for the count and ceiling table.
module cst_dpath #(
   parameter int NUM_SEMAPHORES = cst_pkg::DEF_NUM_SEMAPHORES,
   parameter int NUM_TASKS      = cst_pkg::DEF_NUM_TASKS,
   parameter int COUNT_BITS     = cst_pkg::DEF_COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  cst_pkg::req_type req_data,
   output cst_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data,
   input  cst_pkg::cmd_type cmd,
   output cst_pkg::sts_type sts
);

   localparam int SEM_ADDR_W = NUM_SEMAPHORES > 1 ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int WAIT_SLOTS = NUM_TASKS < cst_pkg::TASK_FIELD_LIMIT ?
                               NUM_TASKS : cst_pkg::TASK_FIELD_LIMIT;
   localparam int RAM_W      = COUNT_BITS + cst_pkg::CEIL_BITS;

   cst_pkg::req_type                   req_ff;
   cst_pkg::rsp_type                   rsp_data_ff, rsp_data_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               mce_ff;
   logic [cst_pkg::STATUS_BITS-1:0]    status_ff, status_in;
   logic [WAIT_SLOTS-1:0]              pending_ff, pending_in;
   logic                               sem_valid_ff [NUM_SEMAPHORES];
   logic                               waiter_valid_ff [WAIT_SLOTS];
   logic                               waiter_valid_in [WAIT_SLOTS];
   logic [SEM_ADDR_W-1:0]              waiter_sem_ff [WAIT_SLOTS];
   logic [SEM_ADDR_W-1:0]              waiter_sem_in [WAIT_SLOTS];

   logic [SEM_ADDR_W-1:0]              sem_addr;
   logic [RAM_W-1:0]                   ram_rd;
   logic                               ram_we;
   logic [COUNT_BITS-1:0]              cnt, cnt_new;
   logic [cst_pkg::CEIL_BITS-1:0]      ceil, ceil_new;
   logic                               sem_ok, task_ok, cnt_zero, cnt_full;
   logic                               record, wake;
   logic [WAIT_SLOTS-1:0]              match, pick;
   logic [cst_pkg::TASK_BITS-1:0]      pick_task;

   assign sem_addr = req_ff.sem_id[SEM_ADDR_W-1:0];
   assign sem_ok   = req_ff.sem_id < cst_pkg::SEM_ID_BITS'(NUM_SEMAPHORES);
   assign task_ok  = {3'b000, req_ff.task_id} < 7'(NUM_TASKS);

   // The table is written only in the execute cycle, when the read data
   // belongs to the request held in req_ff.
   cst_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_SEMAPHORES)
   ) u_sem_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && ram_we),
      .wr_addr (sem_addr),
      .wr_data ({ceil_new, cnt_new}),
      .rd_en   (cmd.read_sem),
      .rd_addr (sem_addr),
      .rd_data (ram_rd)
   );

   // Entries never written since reset read as zero.
   always_comb begin
      cnt  = '0;
      ceil = '0;
      if (sem_ok && sem_valid_ff[sem_addr]) begin
         cnt  = ram_rd[COUNT_BITS-1:0];
         ceil = ram_rd[RAM_W-1:COUNT_BITS];
      end
   end

   assign cnt_zero = cnt == '0;
   assign cnt_full = cnt == '1;

   always_comb begin
      for (int t = 0; t < WAIT_SLOTS; t++) begin
         match[t] = waiter_valid_ff[t] && waiter_sem_ff[t] == sem_addr;
      end
   end

   // Decision for the request held in req_ff, used in the execute cycle.
   always_comb begin
      status_in = cst_pkg::ST_OK;
      ram_we    = 1'b0;
      cnt_new   = cnt;
      ceil_new  = ceil;
      record    = 1'b0;
      wake      = 1'b0;
      if (req_ff.mode == cst_pkg::MODE_SET_CEIL && !mce_ff) begin
         status_in = cst_pkg::ST_OK;
      end else if (!sem_ok) begin
         status_in = cst_pkg::ST_BAD_ID;
      end else begin
         unique case (req_ff.mode)
            cst_pkg::MODE_TRY_WAIT,
            cst_pkg::MODE_WAIT: begin
               if (!cnt_zero) begin
                  ram_we  = 1'b1;
                  cnt_new = cnt - 1'b1;
               end else if (req_ff.mode == cst_pkg::MODE_TRY_WAIT) begin
                  status_in = cst_pkg::ST_NOT_ACQUIRED;
               end else if (!task_ok) begin
                  status_in = cst_pkg::ST_BAD_ID;
               end else begin
                  record    = 1'b1;
                  status_in = cst_pkg::ST_NOT_ACQUIRED;
               end
            end
            cst_pkg::MODE_POST: begin
               if (mce_ff && ceil == '0) begin
                  status_in = cst_pkg::ST_CEIL_UNSET;
               end else if (mce_ff && cnt >= COUNT_BITS'(ceil)) begin
                  status_in = cst_pkg::ST_CEIL_EXCEEDED;
               end else if (cnt_full) begin
                  status_in = cst_pkg::ST_OVERFLOW;
               end else begin
                  ram_we  = 1'b1;
                  cnt_new = cnt + 1'b1;
                  wake    = cnt_zero;
               end
            end
            default: begin
               if (req_ff.new_max == '0) begin
                  status_in = cst_pkg::ST_BAD_CEIL;
               end else if (ceil != '0) begin
                  status_in = cst_pkg::ST_CEIL_ALREADY;
               end else begin
                  ram_we   = 1'b1;
                  ceil_new = req_ff.new_max;
               end
            end
         endcase
      end
   end

   // Lowest pending waiter goes out first.
   assign pick = pending_ff & (~pending_ff + 1'b1);

   always_comb begin
      pick_task = '0;
      for (int t = 0; t < WAIT_SLOTS; t++) begin
         if (pick[t]) begin
            pick_task = pick_task | cst_pkg::TASK_BITS'(t);
         end
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (cmd.exec) begin
         pending_in = wake ? match : '0;
      end else if (cmd.load_wake) begin
         pending_in = pending_ff & ~pick;
      end
   end

   always_comb begin
      for (int t = 0; t < WAIT_SLOTS; t++) begin
         waiter_valid_in[t] = waiter_valid_ff[t];
         waiter_sem_in[t]   = waiter_sem_ff[t];
         if (cmd.exec && wake && match[t]) begin
            waiter_valid_in[t] = 1'b0;
         end
         if (cmd.exec && record && req_ff.task_id == cst_pkg::TASK_BITS'(t)) begin
            waiter_valid_in[t] = 1'b1;
            waiter_sem_in[t]   = sem_addr;
         end
      end
   end

   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.wake_any  = wake && (match != '0);
   assign sts.wake_last = (pending_ff & (pending_ff - 1'b1)) == '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_wake) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = cst_pkg::ST_OK;
         rsp_data_in.woken_valid = 1'b1;
         rsp_data_in.woken_task  = pick_task;
         rsp_data_in.last_result = 1'b0;
      end else if (cmd.load_final) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = status_ff;
         rsp_data_in.woken_valid = 1'b0;
         rsp_data_in.woken_task  = '0;
         rsp_data_in.last_result = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mce_ff       <= 1'b0;
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            sem_valid_ff[i] <= 1'b0;
         end
         for (int t = 0; t < WAIT_SLOTS; t++) begin
            waiter_valid_ff[t] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            mce_ff <= csr_data;
         end
         if (cmd.exec && ram_we) begin
            sem_valid_ff[sem_addr] <= 1'b1;
         end
         for (int t = 0; t < WAIT_SLOTS; t++) begin
            waiter_valid_ff[t] <= waiter_valid_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
      pending_ff  <= reset ? '0 : pending_in;
      rsp_data_ff <= rsp_data_in;
      for (int t = 0; t < WAIT_SLOTS; t++) begin
         waiter_sem_ff[t] <= waiter_sem_in[t];
      end
   end

endmodule

>>> rtl/counting_semaphore_table_unit.sv
// Top level of the counting semaphore table unit.
// Depends on cst_pkg; instantiates cst_ctrl and cst_dpath.
//
// The block keeps a table of counting semaphores and a map of tasks that
// wait on them. Requests arrive as items on the req_ channel (valid/ready),
// results leave as items on the rsp_ channel (valid/ready). The csr_ channel
// writes the one-bit ceiling check enable; it is always ready and should be
// written only while no request is in flight.
//
// Each request yields one or more result items. A post on an empty
// semaphore first emits one item per released waiter, lowest task first,
// and then the final item that carries the status with last_result set.
// One request is handled at a time: accept, table read, execute, then the
// result items in order, each loaded into the result register when it is free.
//
// Results sit in an output register. When the receiver stalls, the block
// holds the item and waits; the next request can be accepted as soon as
// the previous final item has been loaded, even if it has not been taken.
// Synchronous reset empties the table (all counts and ceilings zero), clears
// the waiter map and the check enable, and drops any pending result.
module counting_semaphore_table_unit #(
   parameter int NUM_SEMAPHORES = cst_pkg::DEF_NUM_SEMAPHORES,
   parameter int NUM_TASKS      = cst_pkg::DEF_NUM_TASKS,
   parameter int COUNT_BITS     = cst_pkg::DEF_COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   cst_pkg::cmd_type cmd;
   cst_pkg::sts_type sts;

   // The controller sequences each request through its phases.
   cst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds all table state and the result register.
   cst_dpath #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .NUM_TASKS      (NUM_TASKS),
      .COUNT_BITS     (COUNT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Only one request is in flight: acceptance closes the input.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // The result register is loaded only when it is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_wake || cmd.load_final) |-> sts.out_free)
      else $error("result register overwritten");

   // While idle, any result still waiting is the final item of a request.
   a_idle_final: assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> rsp_data.last_result)
      else $error("idle with release items outstanding");

endmodule
